FILE: hdl/cvrc_pkg.sv
// shared types, constants and functions of the cell voltage readback checker
package cvrc_pkg;

   localparam int MAX_DEVICES      = 5;
   localparam int CELLS_PER_DEVICE = 12;
   localparam int CELLS_PER_GROUP  = 3;
   localparam int DATA_BYTES       = 6;

   localparam int BYTE_W    = 8;
   localparam int GROUP_W   = 2;
   localparam int DEV_W     = 3;
   localparam int SLOT_W    = 6;
   localparam int VOLT_W    = 16;
   localparam int PEC_W     = 15;
   localparam int POS_W     = 3;
   localparam int CNT_W     = $clog2(CELLS_PER_DEVICE + 1);
   localparam int MASK_W    = MAX_DEVICES * CELLS_PER_DEVICE;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = MASK_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PEC_W-1:0] PEC_SEED = 15'd16;
   localparam logic [PEC_W-1:0] PEC_POLY = 15'h4599;

   // byte positions inside one device frame
   localparam logic [POS_W-1:0] POS_PEC_HIGH = 3'd6;
   localparam logic [POS_W-1:0] POS_PEC_LOW  = 3'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_MASK    = 1'd1;

   // result kinds
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // one checked frame handed from front to back
   typedef struct packed {
      logic                                  is_error;
      logic [DEV_W-1:0]                      device;
      logic [SLOT_W-1:0]                     base_slot;
      logic [CELLS_PER_GROUP-1:0]            enables;
      logic [CELLS_PER_GROUP-1:0][VOLT_W-1:0] volts;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // byte-wise crc15, msb first
   function automatic logic [PEC_W-1:0] pec_update(input logic [PEC_W-1:0] rem_in,
                                                   input logic [BYTE_W-1:0] data);
      logic [PEC_W-1:0] rem;
      logic             fb;
      rem = rem_in;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         fb  = rem[PEC_W-1] ^ data[b];
         rem = {rem[PEC_W-2:0], 1'b0};
         if (fb) begin
            rem = rem ^ PEC_POLY;
         end
      end
      return rem;
   endfunction

   function automatic logic [CNT_W-1:0] popcount12(input logic [CELLS_PER_DEVICE-1:0] bits);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < CELLS_PER_DEVICE; i++) begin
         n = n + CNT_W'(bits[i]);
      end
      return n;
   endfunction

   // cells of a device that lie in groups below the given one
   function automatic logic [CELLS_PER_DEVICE-1:0] group_low_mask(input logic [GROUP_W-1:0] grp);
      logic [CELLS_PER_DEVICE-1:0] m;
      case (grp)
         2'd0:    m = 12'h000;
         2'd1:    m = 12'h007;
         2'd2:    m = 12'h03F;
         default: m = 12'h1FF;
      endcase
      return m;
   endfunction

endpackage

FILE: hdl/cvrc_req_if.sv
// readback byte channel
interface cvrc_req_if;
   import cvrc_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   rx_byte;
   logic                start_of_group;
   logic [GROUP_W-1:0]  group_number;

   modport source (output valid, output rx_byte, output start_of_group,
                   output group_number, input ready);
   modport sink   (input valid, input rx_byte, input start_of_group,
                   input group_number, output ready);
endinterface

FILE: hdl/cvrc_rsp_if.sv
// result channel
interface cvrc_rsp_if;
   import cvrc_pkg::*;

   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [DEV_W-1:0]   device_number;
   logic [SLOT_W-1:0]  cell_slot;
   logic [VOLT_W-1:0]  cell_voltage;
   logic               last_of_run;

   modport source (output valid, output result_kind, output device_number,
                   output cell_slot, output cell_voltage, output last_of_run,
                   input ready);
   modport sink   (input valid, input result_kind, input device_number,
                   input cell_slot, input cell_voltage, input last_of_run,
                   output ready);
endinterface

FILE: hdl/cvrc_front.sv
// front end: byte framing, crc check, slot base and configuration registers
module cvrc_front (
   input  logic                                clock,
   input  logic                                reset,
   cvrc_req_if.sink                            req,
   input  logic                                csr_write_enable,
   input  logic [cvrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cvrc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  cvrc_pkg::queue_status_type          q_status,
   output logic                                q_push,
   output cvrc_pkg::job_type                   q_job
);
   import cvrc_pkg::*;

   logic [DEV_W-1:0]            dev_count_ff;
   logic [CELLS_PER_DEVICE-1:0] mask_chunk_ff [MAX_DEVICES];
   logic [CNT_W-1:0]            chunk_cnt_ff  [MAX_DEVICES];

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [DEV_W-1:0]   dev_ff, dev_in;
   logic [PEC_W-1:0]   pec_ff, pec_in;
   logic               abandon_ff, abandon_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [BYTE_W-1:0]  frame_ff [DATA_BYTES];
   logic [BYTE_W-1:0]  pec_hi_ff;

   logic               accept;
   logic [POS_W-1:0]   eff_pos;
   logic [DEV_W-1:0]   eff_dev;
   logic [PEC_W-1:0]   eff_pec;
   logic               eff_abandon;
   logic [GROUP_W-1:0] eff_group;
   logic [DEV_W-1:0]   active_devs;
   logic               take_byte;
   logic               frame_end;
   logic               pec_match;
   logic [CELLS_PER_DEVICE-1:0] dev_chunk;
   logic [SLOT_W-1:0]  base_slot;
   logic [CELLS_PER_GROUP-1:0] cell_en;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   // configuration writes, chunk popcounts kept alongside the mask
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_count_ff <= DEV_W'(1);
         for (int d = 0; d < MAX_DEVICES; d++) begin
            mask_chunk_ff[d] <= '1;
            chunk_cnt_ff[d]  <= CNT_W'(CELLS_PER_DEVICE);
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DEVICE_COUNT: dev_count_ff <= csr_write_data[DEV_W-1:0];
            REG_CELL_MASK: begin
               for (int d = 0; d < MAX_DEVICES; d++) begin
                  mask_chunk_ff[d] <= csr_write_data[d*CELLS_PER_DEVICE +: CELLS_PER_DEVICE];
                  chunk_cnt_ff[d]  <= popcount12(
                     csr_write_data[d*CELLS_PER_DEVICE +: CELLS_PER_DEVICE]);
               end
            end
         endcase
      end
   end

   // device count clamped to 1..MAX_DEVICES
   always_comb begin
      if (dev_count_ff == '0) begin
         active_devs = DEV_W'(1);
      end else if (dev_count_ff > DEV_W'(MAX_DEVICES)) begin
         active_devs = DEV_W'(MAX_DEVICES);
      end else begin
         active_devs = dev_count_ff;
      end
   end

   // state as seen after a start of group
   always_comb begin
      if (req.start_of_group) begin
         eff_pos     = '0;
         eff_dev     = '0;
         eff_pec     = PEC_SEED;
         eff_abandon = 1'b0;
         eff_group   = req.group_number;
      end else begin
         eff_pos     = pos_ff;
         eff_dev     = dev_ff;
         eff_pec     = pec_ff;
         eff_abandon = abandon_ff;
         eff_group   = group_ff;
      end
   end

   assign take_byte = accept && !eff_abandon && (eff_dev < active_devs);
   assign frame_end = take_byte && (eff_pos == POS_PEC_LOW);
   assign pec_match = ({pec_hi_ff, req.rx_byte} == {eff_pec, 1'b0});

   // slot base: enabled cells of lower devices and lower groups
   always_comb begin
      dev_chunk = (eff_dev < DEV_W'(MAX_DEVICES)) ? mask_chunk_ff[eff_dev] : '0;
      base_slot = '0;
      for (int d = 0; d < MAX_DEVICES; d++) begin
         if (DEV_W'(d) < eff_dev) begin
            base_slot = base_slot + SLOT_W'(chunk_cnt_ff[d]);
         end
      end
      base_slot = base_slot + SLOT_W'(popcount12(dev_chunk & group_low_mask(eff_group)));
      cell_en   = CELLS_PER_GROUP'(dev_chunk >> (4'(eff_group) * 4'd3));
   end

   // next framing state
   always_comb begin
      pos_in     = pos_ff;
      dev_in     = dev_ff;
      pec_in     = pec_ff;
      abandon_in = abandon_ff;
      group_in   = group_ff;
      if (accept) begin
         pos_in     = eff_pos;
         dev_in     = eff_dev;
         pec_in     = eff_pec;
         abandon_in = eff_abandon;
         group_in   = eff_group;
      end
      if (take_byte) begin
         if (eff_pos < POS_PEC_HIGH) begin
            pec_in = pec_update(eff_pec, req.rx_byte);
            pos_in = eff_pos + POS_W'(1);
         end else if (eff_pos == POS_PEC_HIGH) begin
            pos_in = POS_PEC_LOW;
         end else begin
            pos_in     = '0;
            pec_in     = PEC_SEED;
            dev_in     = eff_dev + DEV_W'(1);
            abandon_in = !pec_match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         dev_ff     <= '0;
         pec_ff     <= PEC_SEED;
         abandon_ff <= 1'b0;
         group_ff   <= '0;
      end else begin
         pos_ff     <= pos_in;
         dev_ff     <= dev_in;
         pec_ff     <= pec_in;
         abandon_ff <= abandon_in;
         group_ff   <= group_in;
      end
   end

   // frame data bytes and pec high byte
   always_ff @(posedge clock) begin
      if (take_byte && eff_pos < POS_PEC_HIGH) begin
         frame_ff[eff_pos] <= req.rx_byte;
      end
      if (take_byte && eff_pos == POS_PEC_HIGH) begin
         pec_hi_ff <= req.rx_byte;
      end
   end

   // job to the back end: an error, or a good frame with enabled cells
   always_comb begin
      q_job.is_error  = !pec_match;
      q_job.device    = eff_dev;
      q_job.base_slot = base_slot;
      q_job.enables   = cell_en;
      for (int c = 0; c < CELLS_PER_GROUP; c++) begin
         q_job.volts[c] = {frame_ff[2*c+1], frame_ff[2*c]};
      end
      q_push = frame_end && (!pec_match || cell_en != '0);
   end

endmodule

FILE: hdl/cvrc_queue.sv
// small job queue between front and back
module cvrc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cvrc_pkg::job_type           push_job,
   input  logic                        pop,
   output cvrc_pkg::job_type           head_job,
   output cvrc_pkg::queue_status_type  status
);
   import cvrc_pkg::*;

   job_type                store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_job     = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full && !pop |-> !push)
      else $error("push into full job queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty job queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("job queue count out of range");
`endif

endmodule

FILE: hdl/cvrc_back.sv
// back end: expands each job into result transfers through an output register
module cvrc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cvrc_pkg::job_type           head_job,
   input  cvrc_pkg::queue_status_type  q_status,
   output logic                        q_pop,
   cvrc_rsp_if.source                  rsp
);
   import cvrc_pkg::*;

   logic [CELLS_PER_GROUP-1:0] done_ff, done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [DEV_W-1:0]           rsp_dev_ff, rsp_dev_in;
   logic [SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [VOLT_W-1:0]          rsp_volt_ff, rsp_volt_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       job_valid;
   logic                       out_load;
   logic [CELLS_PER_GROUP-1:0] remaining;
   logic [CELLS_PER_GROUP-1:0] pick;
   logic [CELLS_PER_GROUP-1:0] rest;
   logic [SLOT_W-1:0]          pick_slot;
   logic [VOLT_W-1:0]          pick_volt;

   assign job_valid = !q_status.empty;
   assign out_load  = !rsp_valid_ff || rsp.ready;
   assign remaining = head_job.enables & ~done_ff;
   assign rest      = remaining & ~pick;

   // lowest cell still to emit and its compacted slot
   always_comb begin
      pick      = '0;
      pick_slot = head_job.base_slot;
      pick_volt = head_job.volts[0];
      if (remaining[0]) begin
         pick = 3'b001;
      end else if (remaining[1]) begin
         pick      = 3'b010;
         pick_slot = head_job.base_slot + SLOT_W'(head_job.enables[0]);
         pick_volt = head_job.volts[1];
      end else begin
         pick      = 3'b100;
         pick_slot = head_job.base_slot + SLOT_W'(head_job.enables[0])
                     + SLOT_W'(head_job.enables[1]);
         pick_volt = head_job.volts[2];
      end
   end

   // next output register contents and job progress
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dev_in   = rsp_dev_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_volt_in  = rsp_volt_ff;
      rsp_last_in  = rsp_last_ff;
      done_in      = done_ff;
      q_pop        = 1'b0;
      if (out_load && job_valid) begin
         rsp_valid_in = 1'b1;
         rsp_dev_in   = head_job.device;
         if (head_job.is_error) begin
            rsp_kind_in = KIND_ERROR;
            rsp_slot_in = '0;
            rsp_volt_in = '0;
            rsp_last_in = 1'b1;
            q_pop       = 1'b1;
            done_in     = '0;
         end else begin
            rsp_kind_in = KIND_CELL;
            rsp_slot_in = pick_slot;
            rsp_volt_in = pick_volt;
            rsp_last_in = (rest == '0);
            if (rest == '0) begin
               q_pop   = 1'b1;
               done_in = '0;
            end else begin
               done_in = done_ff | pick;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_dev_ff  <= rsp_dev_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_kind   = rsp_kind_ff;
   assign rsp.device_number = rsp_dev_ff;
   assign rsp.cell_slot     = rsp_slot_ff;
   assign rsp.cell_voltage  = rsp_volt_ff;
   assign rsp.last_of_run   = rsp_last_ff;

`ifndef SYNTHESIS
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ERROR |-> rsp_last_ff)
      else $error("error result without last_of_run");
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff && rsp_last_ff)
      else $error("job retired without a last result");
   a_progress_needs_job: assert property (@(posedge clock) disable iff (reset)
      done_ff != '0 |-> job_valid && !head_job.is_error)
      else $error("cell progress held with no good job at head");
`endif

endmodule

FILE: hdl/cell_voltage_readback_checker.sv
// top level of the cell voltage readback checker
//
// Takes one readback byte per cycle: each device frame is six data bytes and
// a two-byte PEC, checked with the byte-wise CRC15 in the front end as the
// bytes arrive. On the last byte of a frame the front end pushes one job
// (a PEC error, or the enabled cells of a good frame with their slot base;
// none if a good frame has no enabled cell) into a four-entry queue; the
// back end turns a job into one result per cycle while the result side
// accepts, so a frame yields up to three results. Sustained input rate is
// one byte per cycle; req_bus.ready drops only while the queue is full,
// which happens only when the result side stalls. Results leave through an
// output register, so a waiting result does not block input.
module cell_voltage_readback_checker (
   input  logic                              clock,
   input  logic                              reset,
   cvrc_req_if.sink                          req_bus,
   cvrc_rsp_if.source                        rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [cvrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cvrc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import cvrc_pkg::*;

   logic             q_push;
   logic             q_pop;
   job_type          q_job;
   job_type          head_job;
   queue_status_type q_status;

   cvrc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_job            (q_job)
   );

   cvrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   cvrc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp      (rsp_bus)
   );

endmodule
